// File: sv/bracket_sequence_unrank_assert.svh
// assertion macros for the bracket sequence unrank block
`ifndef BRACKET_SEQUENCE_UNRANK_ASSERT_SVH
`define BRACKET_SEQUENCE_UNRANK_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bsu_pkg.sv
// shared constants, beat types and table addressing for the bracket sequence unrank block
package bsu_pkg;

	localparam int MAX_PAIRS = 32;
	localparam int TBL_DIM   = MAX_PAIRS + 1;
	localparam int TBL_DEPTH = TBL_DIM * TBL_DIM;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int RANK_W    = 56;
	localparam int CNT_W     = 6;

	typedef struct packed {
		logic [CNT_W-1:0]  pairs;
		logic [RANK_W-1:0] rank;
	} in_beat_t;

	typedef struct packed {
		logic bracket;
		logic last;
		logic rank_error;
	} out_beat_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [RANK_W-1:0] data;
	} wr_req_t;

	localparam logic BR_OPEN  = 1'b0;
	localparam logic BR_CLOSE = 1'b1;

	// row = closes remaining, column = opens remaining
	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CNT_W-1:0] c,
		input logic [CNT_W-1:0] o);
		tbl_addr = ADDR_W'(c) * ADDR_W'(TBL_DIM) + ADDR_W'(o);
	endfunction

endpackage

// File: sv/bsu_ram.sv
// generic ram, one write port and two registered read ports
module bsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: sv/bsu_fill.sv
// builds the ballot number table in ram after reset, one entry per cycle
module bsu_fill (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bsu_pkg::RANK_W-1:0] rdata,
	output bsu_pkg::rd_req_t           rd,
	output bsu_pkg::wr_req_t           wr,
	output logic                       done
);

	typedef enum logic [2:0] {
		F_RUN   = 3'b001,
		F_DRAIN = 3'b010,
		F_DONE  = 3'b100
	} fill_state_t;

	localparam logic [bsu_pkg::CNT_W-1:0] CNT_MAX = bsu_pkg::CNT_W'(bsu_pkg::MAX_PAIRS);

	fill_state_t                  state_q;
	logic [bsu_pkg::CNT_W-1:0]    fc_q;
	logic [bsu_pkg::CNT_W-1:0]    fo_q;
	logic [bsu_pkg::ADDR_W-1:0]   fidx_q;
	logic                         fv_s1;
	logic [bsu_pkg::CNT_W-1:0]    fc_s1;
	logic [bsu_pkg::CNT_W-1:0]    fo_s1;
	logic [bsu_pkg::ADDR_W-1:0]   fidx_s1;
	logic [bsu_pkg::RANK_W-1:0]   left_q;
	logic [bsu_pkg::RANK_W-1:0]   val;
	logic                         run;

	assign run  = (state_q == F_RUN);
	assign done = (state_q == F_DONE);

	// entry above sits one row back
	assign rd.en   = run && (fc_q != '0);
	assign rd.addr = fidx_q - bsu_pkg::ADDR_W'(bsu_pkg::TBL_DIM);

	always_comb begin
		if (fc_s1 == '0) begin
			val = (fo_s1 == '0) ? bsu_pkg::RANK_W'(1) : '0;
		end else if (fo_s1 > fc_s1) begin
			val = '0;
		end else if (fo_s1 == '0) begin
			val = rdata;
		end else begin
			val = rdata + left_q;
		end
	end

	assign wr.en   = fv_s1;
	assign wr.addr = fidx_s1;
	assign wr.data = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			fc_q    <= '0;
			fo_q    <= '0;
			fidx_q  <= '0;
			fv_s1   <= 1'b0;
		end else begin
			fv_s1 <= run;
			unique case (state_q)
				F_RUN: begin
					fidx_q <= fidx_q + 1'b1;
					if (fo_q == CNT_MAX) begin
						fo_q <= '0;
						fc_q <= fc_q + 1'b1;
					end else begin
						fo_q <= fo_q + 1'b1;
					end
					if (fc_q == CNT_MAX && fo_q == CNT_MAX) begin
						state_q <= F_DRAIN;
					end
				end
				F_DRAIN: begin
					state_q <= F_DONE;
				end
				F_DONE: begin
					state_q <= F_DONE;
				end
				default: begin
					state_q <= F_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fc_s1   <= fc_q;
		fo_s1   <= fo_q;
		fidx_s1 <= fidx_q;
		if (fv_s1) begin
			left_q <= val;
		end
	end

endmodule

// File: sv/bsu_walk.sv
// request sequencer: catalan check, then one table compare and subtract per bracket
module bsu_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bsu_pkg::in_beat_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bsu_pkg::out_beat_t         out_data,
	output bsu_pkg::rd_req_t           rd_a,
	output bsu_pkg::rd_req_t           rd_b,
	input  logic [bsu_pkg::RANK_W-1:0] rdata_a,
	input  logic [bsu_pkg::RANK_W-1:0] rdata_b
);

	typedef enum logic [3:0] {
		W_IDLE  = 4'b0001,
		W_CHECK = 4'b0010,
		W_STEP  = 4'b0100,
		W_ERR   = 4'b1000
	} walk_state_t;

	localparam int DW = bsu_pkg::CNT_W + 1;

	walk_state_t                state_q;
	walk_state_t                state_d;
	logic [bsu_pkg::CNT_W-1:0]  n_q;
	logic [bsu_pkg::RANK_W-1:0] r_q;
	logic [bsu_pkg::CNT_W-1:0]  op_q;
	logic [bsu_pkg::CNT_W-1:0]  cl_q;
	logic                       sel_q;
	logic                       zero_a_q;
	logic                       zero_b_q;
	logic                       out_valid_q;
	bsu_pkg::out_beat_t         out_q;

	logic                       accept;
	logic                       range_ok;
	logic                       take;
	logic                       load;
	bsu_pkg::out_beat_t         beat;
	logic [bsu_pkg::RANK_W-1:0] cur_c;
	logic                       is_open;
	logic                       is_last;
	logic [DW-1:0]              placed;
	logic [DW-1:0]              ca;
	logic [DW-1:0]              oa;
	logic [DW-1:0]              cb;
	logic [DW-1:0]              ob;
	logic                       za;
	logic                       zb;

	assign in_ready  = enable && (state_q == W_IDLE);
	assign accept    = in_valid && in_ready;
	assign range_ok  = (in_data.pairs != '0) &&
		(in_data.pairs <= bsu_pkg::CNT_W'(bsu_pkg::MAX_PAIRS));
	assign take      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cur_c   = sel_q ? (zero_b_q ? '0 : rdata_b) : (zero_a_q ? '0 : rdata_a);
	assign is_open = (r_q < cur_c);
	assign placed  = DW'(op_q) + DW'(cl_q) + DW'(1);
	assign is_last = (placed == {n_q, 1'b0});

	// candidates for the next position: after an open, after a close
	assign ca = DW'(n_q) - DW'(cl_q);
	assign oa = DW'(n_q) - DW'(op_q) - DW'(2);
	assign cb = DW'(n_q) - DW'(cl_q) - DW'(1);
	assign ob = DW'(n_q) - DW'(op_q) - DW'(1);
	assign za = ca[DW-1] || oa[DW-1];
	assign zb = cb[DW-1] || ob[DW-1];

	always_comb begin
		state_d      = state_q;
		load         = 1'b0;
		beat.bracket = bsu_pkg::BR_OPEN;
		beat.last    = 1'b1;
		beat.rank_error = 1'b1;
		rd_a.en      = 1'b0;
		rd_a.addr    = bsu_pkg::tbl_addr(in_data.pairs, in_data.pairs);
		rd_b.en      = 1'b0;
		rd_b.addr    = bsu_pkg::tbl_addr(cb[bsu_pkg::CNT_W-1:0], ob[bsu_pkg::CNT_W-1:0]);
		unique case (state_q)
			W_IDLE: begin
				if (accept) begin
					rd_a.en = range_ok;
					state_d = range_ok ? W_CHECK : W_ERR;
				end
			end
			W_CHECK: begin
				rd_a.en   = 1'b1;
				rd_a.addr = bsu_pkg::tbl_addr(n_q, n_q - 1'b1);
				state_d   = (r_q >= rdata_a) ? W_ERR : W_STEP;
			end
			W_STEP: begin
				rd_a.addr = bsu_pkg::tbl_addr(ca[bsu_pkg::CNT_W-1:0], oa[bsu_pkg::CNT_W-1:0]);
				if (take) begin
					load            = 1'b1;
					beat.bracket    = is_open ? bsu_pkg::BR_OPEN : bsu_pkg::BR_CLOSE;
					beat.last       = is_last;
					beat.rank_error = 1'b0;
					rd_a.en         = !za && !is_last;
					rd_b.en         = !zb && !is_last;
					if (is_last) begin
						state_d = W_IDLE;
					end
				end
			end
			W_ERR: begin
				if (take) begin
					load    = 1'b1;
					state_d = W_IDLE;
				end
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			cl_q        <= '0;
			r_q         <= '0;
			sel_q       <= 1'b0;
			zero_a_q    <= 1'b0;
			zero_b_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load || (out_valid_q && !out_ready);
			if (accept) begin
				r_q  <= in_data.rank;
				op_q <= '0;
				cl_q <= '0;
			end
			if (state_q == W_CHECK) begin
				sel_q    <= 1'b0;
				zero_a_q <= 1'b0;
			end
			if (state_q == W_STEP && take) begin
				sel_q    <= !is_open;
				zero_a_q <= za;
				zero_b_q <= zb;
				if (is_open) begin
					op_q <= op_q + 1'b1;
				end else begin
					cl_q <= cl_q + 1'b1;
					r_q  <= r_q - cur_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= in_data.pairs;
		end
		if (load) begin
			out_q <= beat;
		end
	end

endmodule

// File: sv/bracket_sequence_unrank.sv
// top level of the bracket sequence unrank block
// Returns the balanced bracket sequence of a given lexicographic rank ('(' before ')'), one
// bracket per output beat with the final one marked last; pairs outside 1..32 or a rank at or
// above the Catalan number give a single beat with rank_error and last set. After reset the
// block builds the 33x33 ballot number table in its ram and accepts no request until then.
// A request passes accept and the Catalan check, then gives one bracket per cycle unless the
// output stalls; a rejected one goes to its error beat, via the Catalan check if pairs is in
// range. Reading both candidate table entries for the next position on the two ram read ports
// while the current compare and subtract completes gives one bracket per cycle. A new request
// is accepted while the last beat of the previous one still waits in the output register.
module bracket_sequence_unrank (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bsu_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bsu_pkg::out_beat_t out_data
);

	bsu_pkg::rd_req_t           fill_rd;
	bsu_pkg::wr_req_t           fill_wr;
	logic                       fill_done;
	bsu_pkg::rd_req_t           walk_rd_a;
	bsu_pkg::rd_req_t           walk_rd_b;
	bsu_pkg::rd_req_t           rd_a;
	logic [bsu_pkg::RANK_W-1:0] rdata_a;
	logic [bsu_pkg::RANK_W-1:0] rdata_b;

	assign rd_a = fill_done ? walk_rd_a : fill_rd;

	bsu_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.rdata  (rdata_a),
		.rd     (fill_rd),
		.wr     (fill_wr),
		.done   (fill_done)
	);

	bsu_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (fill_done),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.rd_a      (walk_rd_a),
		.rd_b      (walk_rd_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b)
	);

	bsu_ram #(
		.WIDTH (bsu_pkg::RANK_W),
		.DEPTH (bsu_pkg::TBL_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (fill_wr.en),
		.waddr   (fill_wr.addr),
		.wdata   (fill_wr.data),
		.re_a    (rd_a.en),
		.raddr_a (rd_a.addr),
		.rdata_a (rdata_a),
		.re_b    (walk_rd_b.en),
		.raddr_b (walk_rd_b.addr),
		.rdata_b (rdata_b)
	);

endmodule

// File: sv/bsu_chk.sv
// port checker for the bracket sequence unrank block and its bind
`include "bracket_sequence_unrank_assert.svh"

module bsu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bsu_pkg::in_beat_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input bsu_pkg::out_beat_t out_data
);

	// an error beat closes its request
	`BSU_ASSERT_SAME(a_err_last, out_valid && out_data.rank_error, out_data.last, "error beat not last")

	// an error beat carries an open bracket code
	`BSU_ASSERT_SAME(a_err_br, out_valid && out_data.rank_error, out_data.bracket == bsu_pkg::BR_OPEN, "error beat bracket set")

	// one request at a time
	`BSU_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "ready right after accept")

	// stalled beat holds
	`BSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

endmodule

bind bracket_sequence_unrank bsu_chk u_bsu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
